// ===== rtl/qmm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// qmm_pkg
// Shared types, widths and constants of the quadrotor motor mixer.
// ============================================================================
package qmm_pkg;

   localparam int MotorCount  = 4;
   localparam int SqWidth     = 42;   // clipped squared speed
   localparam int RootWidth   = SqWidth / 2;
   localparam int RemWidth    = RootWidth + 2;
   localparam int SqrtPerStg  = 3;    // root bits resolved per stage
   localparam int SqrtStages  = RootWidth / SqrtPerStg;
   localparam int PipeDepth   = SqrtStages + 5;
   localparam int ProdWidth   = 53;   // 32 x 21 products
   localparam int EnergyWidth = ProdWidth + RootWidth + 1;
   localparam int DutyLsb     = 24;
   localparam int DutyWidth   = 16;

   // Register indexes of the control port.
   typedef enum logic [2:0] {
      REG_THRUST_GAIN     = 3'd0,
      REG_ROLL_PITCH_GAIN = 3'd1,
      REG_YAW_GAIN        = 3'd2,
      REG_QUAD_COEF       = 3'd3,
      REG_LIN_COEF        = 3'd4
   } reg_index_type;

   // Subtract flags {roll, pitch, yaw} for each motor of the X layout.
   localparam logic [2:0] MotorSigns [MotorCount] = '{3'b111, 3'b100, 3'b001, 3'b010};

   typedef struct packed {
      logic [SqWidth-1:0]   src;
      logic [RemWidth-1:0]  rem;
      logic [RootWidth-1:0] root;
   } sqrt_state_type;

   // Resolve SqrtPerStg root bits, restoring digit-by-digit method.
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st);
      sqrt_state_type       s;
      logic [RemWidth-1:0]  cur;
      logic [RemWidth-1:0]  trial;
      s = st;
      for (int i = 0; i < SqrtPerStg; i++) begin
         cur   = {s.rem[RemWidth-3:0], s.src[SqWidth-1 -: 2]};
         trial = {s.root, 2'b01};
         s.src = {s.src[SqWidth-3:0], 2'b00};
         if (cur >= trial) begin
            s.rem  = cur - trial;
            s.root = {s.root[RootWidth-2:0], 1'b1};
         end else begin
            s.rem  = cur;
            s.root = {s.root[RootWidth-2:0], 1'b0};
         end
      end
      return s;
   endfunction

endpackage

// ===== rtl/quadrotor_motor_mixer_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// quadrotor_motor_mixer_unit
// X-quad mixer: thrust and torques to four PWM duties through Q16.16 gains,
// floor square root and a quadratic motor model.
// ============================================================================
//
//  channel | ports                                   | flow
//  --------+-----------------------------------------+---------------------------
//  req     | start, busy, req_*                      | command word in, start&!busy
//  rsp     | rsp_valid, rsp_*                        | result word out, one cycle
//  csr     | csr_valid, csr_ready, csr_index/data    | register write, valid&ready
//
//  One command word enters every cycle; busy stays low.
//  Pipeline stages: product, sum, seven square-root stages (three root
//  bits each), speed square, coefficient products, duty and clip.
//  Reset clears the valid chain and loads the default gains.
//  The receiver cannot stall, so the pipeline never holds.
//
module quadrotor_motor_mixer_unit
   import qmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [19:0] req_thrust_force,
   input  logic signed [23:0] req_roll_torque,
   input  logic signed [23:0] req_pitch_torque,
   input  logic signed [23:0] req_yaw_torque,
   input  logic        req_armed,
   output logic        rsp_valid,
   output logic [15:0] rsp_motor_one_pwm,
   output logic [15:0] rsp_motor_two_pwm,
   output logic [15:0] rsp_motor_three_pwm,
   output logic [15:0] rsp_motor_four_pwm,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Control registers
   logic [31:0] thrust_gain_ff, rp_gain_ff, yaw_gain_ff, quad_coef_ff, lin_coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thrust_gain_ff <= 32'd949250;
         rp_gain_ff     <= 32'd27121;
         yaw_gain_ff    <= 32'd114896;
         quad_coef_ff   <= 32'd67949;
         lin_coef_ff    <= 32'd257281795;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_THRUST_GAIN:     thrust_gain_ff <= csr_data;
            REG_ROLL_PITCH_GAIN: rp_gain_ff     <= csr_data;
            REG_YAW_GAIN:        yaw_gain_ff    <= csr_data;
            REG_QUAD_COEF:       quad_coef_ff   <= csr_data;
            REG_LIN_COEF:        lin_coef_ff    <= csr_data;
            default: ;           // drop writes beyond the list
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Valid chain travels alongside the data.
   logic [PipeDepth-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PipeDepth-2:0], start & ~busy};
      end
   end

   // Stage 1: gain products
   logic [51:0]        t_ff;
   logic signed [56:0] r_ff, p_ff, y_ff;
   logic               arm_ff;
   always_ff @(posedge clock) begin
      t_ff   <= 52'(req_thrust_force) * 52'(thrust_gain_ff);
      r_ff   <= 57'(req_roll_torque)  * 57'($signed({1'b0, rp_gain_ff}));
      p_ff   <= 57'(req_pitch_torque) * 57'($signed({1'b0, rp_gain_ff}));
      y_ff   <= 57'(req_yaw_torque)   * 57'($signed({1'b0, yaw_gain_ff}));
      arm_ff <= req_armed;
   end

   // Stage 2: mix, clip negatives and disarmed commands to zero
   logic [SqWidth-1:0] sq_ff [MotorCount];
   always_ff @(posedge clock) begin
      logic signed [58:0] acc;
      for (int k = 0; k < MotorCount; k++) begin
         acc = $signed({7'd0, t_ff});
         acc = MotorSigns[k][2] ? acc - 59'(r_ff) : acc + 59'(r_ff);
         acc = MotorSigns[k][1] ? acc - 59'(p_ff) : acc + 59'(p_ff);
         acc = MotorSigns[k][0] ? acc - 59'(y_ff) : acc + 59'(y_ff);
         sq_ff[k] <= (acc[58] || !arm_ff) ? '0 : acc[57:16];
      end
   end

   // Square-root stages
   sqrt_state_type sqrt_ff [SqrtStages][MotorCount];
   always_ff @(posedge clock) begin
      sqrt_state_type seed;
      for (int k = 0; k < MotorCount; k++) begin
         seed.src  = sq_ff[k];
         seed.rem  = '0;
         seed.root = '0;
         sqrt_ff[0][k] <= sqrt_step(seed);
         for (int s = 1; s < SqrtStages; s++) begin
            sqrt_ff[s][k] <= sqrt_step(sqrt_ff[s-1][k]);
         end
      end
   end

   // Speed square
   logic [RootWidth-1:0] w_ff  [MotorCount];
   logic [SqWidth-1:0]   w2_ff [MotorCount];
   always_ff @(posedge clock) begin
      for (int k = 0; k < MotorCount; k++) begin
         w_ff[k]  <= sqrt_ff[SqrtStages-1][k].root;
         w2_ff[k] <= SqWidth'(sqrt_ff[SqrtStages-1][k].root)
                   * SqWidth'(sqrt_ff[SqrtStages-1][k].root);
      end
   end

   // Coefficient products, square split into two halves
   logic [ProdWidth-1:0] ql_ff [MotorCount];
   logic [ProdWidth-1:0] qh_ff [MotorCount];
   logic [ProdWidth-1:0] lw_ff [MotorCount];
   always_ff @(posedge clock) begin
      for (int k = 0; k < MotorCount; k++) begin
         ql_ff[k] <= ProdWidth'(quad_coef_ff) * ProdWidth'(w2_ff[k][RootWidth-1:0]);
         qh_ff[k] <= ProdWidth'(quad_coef_ff) * ProdWidth'(w2_ff[k][SqWidth-1:RootWidth]);
         lw_ff[k] <= ProdWidth'(lin_coef_ff) * ProdWidth'(w_ff[k]);
      end
   end

   // Duty and clip, output register
   logic [DutyWidth-1:0] duty_ff [MotorCount];
   logic                 sat_ff;
   always_ff @(posedge clock) begin
      logic [EnergyWidth-1:0] e;
      logic                   any;
      any = 1'b0;
      for (int k = 0; k < MotorCount; k++) begin
         e = {qh_ff[k], {RootWidth{1'b0}}} + EnergyWidth'(ql_ff[k])
           + EnergyWidth'(lw_ff[k]);
         if (|e[EnergyWidth-1:DutyLsb+DutyWidth]) begin
            duty_ff[k] <= '1;
            any        = 1'b1;
         end else begin
            duty_ff[k] <= e[DutyLsb +: DutyWidth];
         end
      end
      sat_ff <= any;
   end

   assign rsp_valid           = vld_ff[PipeDepth-1];
   assign rsp_motor_one_pwm   = duty_ff[0];
   assign rsp_motor_two_pwm   = duty_ff[1];
   assign rsp_motor_three_pwm = duty_ff[2];
   assign rsp_motor_four_pwm  = duty_ff[3];
   assign rsp_saturated       = sat_ff;

   // A flagged result carries at least one full-scale duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (rsp_motor_one_pwm == 16'hFFFF) || (rsp_motor_two_pwm == 16'hFFFF) ||
         (rsp_motor_three_pwm == 16'hFFFF) || (rsp_motor_four_pwm == 16'hFFFF))
      else $error("saturated flag without a clipped duty");

   // Every accepted command yields its word once it has passed the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##12 rsp_valid)
      else $error("result word missing after pipeline latency");

endmodule
